FILE: design/ofe_pkg.sv
// ofe_pkg: shared widths, reset values and status codes for the off-axis
// frustum extents block. No dependencies; every other file imports it.
`timescale 1ns / 1ps

package ofe_pkg;

   localparam int IN_W          = 24;
   localparam int NEAR_W        = 23;
   localparam int STATUS_W      = 2;
   localparam int FRAC_BITS_DEF = 16;

   localparam logic [NEAR_W-1:0] NEAR_RESET = NEAR_W'(655);

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK     = 2'd0,
      STATUS_BEHIND = 2'd1,
      STATUS_DEGEN  = 2'd2
   } status_type;

endpackage

FILE: design/ofe_req_if.sv
// ofe_req_if / ofe_rsp_if: valid/ready channels carrying one request and one
// result of the frustum extents block. Depends on ofe_pkg.
`timescale 1ns / 1ps

interface ofe_req_if import ofe_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic signed [IN_W-1:0] lower_left_x;
   logic signed [IN_W-1:0] lower_left_y;
   logic signed [IN_W-1:0] lower_left_z;
   logic signed [IN_W-1:0] lower_right_x;
   logic signed [IN_W-1:0] lower_right_y;
   logic signed [IN_W-1:0] lower_right_z;
   logic signed [IN_W-1:0] upper_left_x;
   logic signed [IN_W-1:0] upper_left_y;
   logic signed [IN_W-1:0] upper_left_z;
   logic signed [IN_W-1:0] eye_x;
   logic signed [IN_W-1:0] eye_y;
   logic signed [IN_W-1:0] eye_z;

   modport source (
      output valid, lower_left_x, lower_left_y, lower_left_z,
             lower_right_x, lower_right_y, lower_right_z,
             upper_left_x, upper_left_y, upper_left_z, eye_x, eye_y, eye_z,
      input  ready
   );
   modport sink (
      input  valid, lower_left_x, lower_left_y, lower_left_z,
             lower_right_x, lower_right_y, lower_right_z,
             upper_left_x, upper_left_y, upper_left_z, eye_x, eye_y, eye_z,
      output ready
   );
endinterface

interface ofe_rsp_if import ofe_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic signed [IN_W-1:0] extent_left;
   logic signed [IN_W-1:0] extent_right;
   logic signed [IN_W-1:0] extent_bottom;
   logic signed [IN_W-1:0] extent_top;
   logic [STATUS_W-1:0]    status;

   modport source (
      output valid, extent_left, extent_right, extent_bottom, extent_top, status,
      input  ready
   );
   modport sink (
      input  valid, extent_left, extent_right, extent_bottom, extent_top, status,
      output ready
   );
endinterface

FILE: design/ofe_isqrt.sv
// ofe_isqrt: pipelined floor square root, one root bit per register stage,
// several lanes in lockstep with a sideband word. Depends on ofe_pkg.
`timescale 1ns / 1ps

module ofe_isqrt import ofe_pkg::*; #(
   parameter int LANES = 1,
   parameter int XW    = 52,
   parameter int SBW   = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [XW-1:0]     in_x [LANES],
   input  logic [SBW-1:0]    in_sb,
   output logic              out_valid,
   output logic [XW/2-1:0]   out_root [LANES],
   output logic [SBW-1:0]    out_sb
);

   localparam int RW = XW / 2;

   logic           valid_ff [RW];
   logic [SBW-1:0] sb_ff    [RW];
   logic [XW-1:0]  x_ff     [RW-1][LANES];
   logic [RW+1:0]  rem_ff   [RW][LANES];
   logic [RW-1:0]  root_ff  [RW][LANES];

   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic           src_valid;
      logic [SBW-1:0] src_sb;
      logic [XW-1:0]  src_x    [LANES];
      logic [RW+1:0]  src_rem  [LANES];
      logic [RW-1:0]  src_root [LANES];

      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_sb    = in_sb;
         for (genvar l = 0; l < LANES; l++) begin : g_lane
            assign src_x[l]    = in_x[l];
            assign src_rem[l]  = '0;
            assign src_root[l] = '0;
         end
      end else begin : g_next
         assign src_valid = valid_ff[k-1];
         assign src_sb    = sb_ff[k-1];
         for (genvar l = 0; l < LANES; l++) begin : g_lane
            assign src_x[l]    = x_ff[k-1][l];
            assign src_rem[l]  = rem_ff[k-1][l];
            assign src_root[l] = root_ff[k-1][l];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sb_ff[k] <= src_sb;
         end
      end

      for (genvar l = 0; l < LANES; l++) begin : g_lane_step
         logic [RW+3:0] t;
         logic [RW+3:0] trial;
         logic          ge;
         logic [RW+1:0] rem_in;
         logic [RW-1:0] root_in;

         always_comb begin
            t       = {src_rem[l], src_x[l][XW-1 -: 2]};
            trial   = (RW+4)'({src_root[l], 2'b01});
            ge      = (t >= trial);
            rem_in  = ge ? (RW+2)'(t - trial) : (RW+2)'(t);
            root_in = {src_root[l][RW-2:0], ge};
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k][l]  <= rem_in;
               root_ff[k][l] <= root_in;
            end
         end

         if (k < RW-1) begin : g_xreg
            always_ff @(posedge clock) begin
               if (en) begin
                  x_ff[k][l] <= src_x[l] << 2;
               end
            end
         end
      end
   end

   assign out_valid = valid_ff[RW-1];
   assign out_sb    = sb_ff[RW-1];
   for (genvar l = 0; l < LANES; l++) begin : g_out
      assign out_root[l] = root_ff[RW-1][l];
   end

endmodule

FILE: design/ofe_div.sv
// ofe_div: pipelined signed-by-positive divider, truncating, one quotient bit
// per stage and a final sign/saturate stage. Depends on ofe_pkg.
`timescale 1ns / 1ps

module ofe_div import ofe_pkg::*; #(
   parameter int LANES = 1,
   parameter int NW    = 53,
   parameter int DW    = 28,
   parameter int QW    = 23,
   parameter int SBW   = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic signed [NW-1:0] in_num [LANES],
   input  logic [DW-1:0]      in_den [LANES],
   input  logic [SBW-1:0]     in_sb,
   output logic               out_valid,
   output logic signed [QW:0] out_quo [LANES],
   output logic [SBW-1:0]     out_sb
);

   localparam logic signed [QW:0] QMAX = {1'b0, {QW{1'b1}}};
   localparam logic signed [QW:0] QMIN = {1'b1, {QW{1'b0}}};

   logic           valid_ff [QW];
   logic [SBW-1:0] sb_ff    [QW];
   logic [QW-1:0]  q_ff     [QW][LANES];
   logic           neg_ff   [QW][LANES];
   logic           ovf_ff   [QW][LANES];
   logic [DW-1:0]  rem_ff   [QW-1][LANES];
   logic [QW-1:0]  low_ff   [QW-1][LANES];
   logic [DW-1:0]  den_ff   [QW-1][LANES];

   logic               fin_valid_ff;
   logic [SBW-1:0]     fin_sb_ff;
   logic signed [QW:0] quo_ff [LANES];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic           src_valid;
      logic [SBW-1:0] src_sb;
      logic [DW-1:0]  src_rem [LANES];
      logic [QW-1:0]  src_low [LANES];
      logic [DW-1:0]  src_den [LANES];
      logic [QW-1:0]  src_q   [LANES];
      logic           src_neg [LANES];
      logic           src_ovf [LANES];

      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_sb    = in_sb;
         for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [NW-1:0] mag;
            logic [NW-1:0] hi;
            always_comb begin
               mag        = in_num[l][NW-1] ? NW'(-in_num[l]) : NW'(in_num[l]);
               hi         = mag >> QW;
               src_neg[l] = in_num[l][NW-1];
               // quotient would not fit in QW bits
               src_ovf[l] = (hi >= NW'(in_den[l]));
               src_rem[l] = hi[DW-1:0];
               src_low[l] = mag[QW-1:0];
               src_den[l] = in_den[l];
               src_q[l]   = '0;
            end
         end
      end else begin : g_next
         assign src_valid = valid_ff[k-1];
         assign src_sb    = sb_ff[k-1];
         for (genvar l = 0; l < LANES; l++) begin : g_lane
            assign src_rem[l] = rem_ff[k-1][l];
            assign src_low[l] = low_ff[k-1][l];
            assign src_den[l] = den_ff[k-1][l];
            assign src_q[l]   = q_ff[k-1][l];
            assign src_neg[l] = neg_ff[k-1][l];
            assign src_ovf[l] = ovf_ff[k-1][l];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sb_ff[k] <= src_sb;
         end
      end

      for (genvar l = 0; l < LANES; l++) begin : g_lane_step
         logic [DW:0]   t;
         logic [DW:0]   den_x;
         logic          ge;
         logic [QW-1:0] q_in;

         always_comb begin
            t     = {src_rem[l], src_low[l][QW-1]};
            den_x = {1'b0, src_den[l]};
            ge    = (t >= den_x);
            q_in  = {src_q[l][QW-2:0], ge};
         end

         always_ff @(posedge clock) begin
            if (en) begin
               q_ff[k][l]   <= q_in;
               neg_ff[k][l] <= src_neg[l];
               ovf_ff[k][l] <= src_ovf[l];
            end
         end

         if (k < QW-1) begin : g_carry
            always_ff @(posedge clock) begin
               if (en) begin
                  rem_ff[k][l] <= ge ? DW'(t - den_x) : DW'(t);
                  low_ff[k][l] <= src_low[l] << 1;
                  den_ff[k][l] <= src_den[l];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (en) begin
         fin_valid_ff <= valid_ff[QW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fin_sb_ff <= sb_ff[QW-1];
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_fin
      logic signed [QW:0] quo_in;
      logic signed [QW:0] mag_s;
      always_comb begin
         mag_s = $signed({1'b0, q_ff[QW-1][l]});
         if (ovf_ff[QW-1][l]) begin
            quo_in = neg_ff[QW-1][l] ? QMIN : QMAX;
         end else begin
            quo_in = neg_ff[QW-1][l] ? -mag_s : mag_s;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            quo_ff[l] <= quo_in;
         end
      end
      assign out_quo[l] = quo_ff[l];
   end

   assign out_valid = fin_valid_ff;
   assign out_sb    = fin_sb_ff;

endmodule

FILE: design/off_axis_frustum_extents.sv
// off_axis_frustum_extents: top level of the generalised perspective extents
// pipeline. Depends on ofe_pkg, ofe_req_if/ofe_rsp_if, ofe_isqrt and ofe_div.
//
// Usage
//   req_bus  : one request per handshake: lower-left, lower-right and
//              upper-left screen corners and the eye, signed Q8.FRAC_BITS.
//   rsp_bus  : one result per request, in order: left, right, bottom, top
//              extents at the near plane (saturated) and a status code
//              (ok, eye not in front of the screen, degenerate screen).
//   csr_we / csr_wdata : near plane distance, unsigned with FRAC_BITS
//              fraction bits; write only while the pipeline is empty.
//   Throughput : one request per cycle, sustained unless a result is held.
//   Pipeline   : the two square root and three divider pipelines
//              compute one result bit per stage.
//   Reset      : clears every stage valid bit, including the result valid bit, and
//              loads the near distance with 0.01.
//   Stall      : while a result waits on rsp_bus the whole pipeline holds
//              and req_bus.ready is low; nothing is dropped or repeated.
`timescale 1ns / 1ps

module off_axis_frustum_extents import ofe_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   ofe_req_if.sink           req_bus,
   ofe_rsp_if.source         rsp_bus,
   input  logic              csr_we,
   input  logic [NEAR_W-1:0] csr_wdata
);

   localparam int F   = FRAC_BITS;
   localparam int DFW = IN_W + 1;        // corner differences
   localparam int ESW = 2 * DFW + 2;     // edge squared length
   localparam int ELW = ESW / 2;
   localparam int UW  = F + 2;           // unit vector components
   localparam int CW  = F + 3;           // cross product components
   localparam int CQW = 2 * F + 3;
   localparam int CSW = 2 * F + 4;
   localparam int CLW = CSW / 2;
   localparam int PW  = DFW + UW;        // dot product terms
   localparam int DTW = IN_W + 5;        // dot products after flooring
   localparam int DDW = DTW - 1;
   localparam int NPW = DTW + NEAR_W + 1;
   localparam int EQW = IN_W - 1;

   typedef logic [2:0][DFW-1:0] dvec_type;
   typedef logic [2:0][UW-1:0]  uvec_type;
   typedef logic [2:0][CW-1:0]  cvec_type;

   typedef struct packed {
      dvec_type er;
      dvec_type eu;
      dvec_type va;
      dvec_type vb;
      dvec_type vc;
   } sb1_type;

   typedef struct packed {
      dvec_type va;
      dvec_type vb;
      dvec_type vc;
      logic     degen;
   } sb2_type;

   typedef struct packed {
      cvec_type cr;
      uvec_type ur;
      uvec_type uu;
      dvec_type va;
      dvec_type vb;
      dvec_type vc;
      logic     degen;
   } sb3_type;

   typedef struct packed {
      uvec_type ur;
      uvec_type uu;
      dvec_type va;
      dvec_type vb;
      dvec_type vc;
      logic     degen;
   } sb4_type;

   logic en;
   logic [NEAR_W-1:0] near_ff;

   logic                rsp_valid_ff;
   logic signed [IN_W-1:0] rsp_ext_ff [4];
   status_type          rsp_status_ff;

   // whole pipeline advances together unless a result is held
   assign en            = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         near_ff <= NEAR_RESET;
      end else if (csr_we) begin
         near_ff <= csr_wdata;
      end
   end

   // ---- stage a: differences ----
   logic signed [IN_W-1:0] pa [3], pb [3], pc [3], pe [3];
   assign pa[0] = req_bus.lower_left_x;
   assign pa[1] = req_bus.lower_left_y;
   assign pa[2] = req_bus.lower_left_z;
   assign pb[0] = req_bus.lower_right_x;
   assign pb[1] = req_bus.lower_right_y;
   assign pb[2] = req_bus.lower_right_z;
   assign pc[0] = req_bus.upper_left_x;
   assign pc[1] = req_bus.upper_left_y;
   assign pc[2] = req_bus.upper_left_z;
   assign pe[0] = req_bus.eye_x;
   assign pe[1] = req_bus.eye_y;
   assign pe[2] = req_bus.eye_z;

   logic     a_valid_ff;
   sb1_type  a_in, a_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_in.er[i] = DFW'(pb[i]) - DFW'(pa[i]);
         a_in.eu[i] = DFW'(pc[i]) - DFW'(pa[i]);
         a_in.va[i] = DFW'(pa[i]) - DFW'(pe[i]);
         a_in.vb[i] = DFW'(pb[i]) - DFW'(pe[i]);
         a_in.vc[i] = DFW'(pc[i]) - DFW'(pe[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff <= a_in;
      end
   end

   // ---- stage b: edge squares ----
   logic                      b_valid_ff;
   sb1_type                   b_ff;
   logic [2:0][2*DFW-1:0]     b_sqr_in, b_squ_in, b_sqr_ff, b_squ_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         b_sqr_in[i] = $signed(a_ff.er[i]) * $signed(a_ff.er[i]);
         b_squ_in[i] = $signed(a_ff.eu[i]) * $signed(a_ff.eu[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_ff     <= a_ff;
         b_sqr_ff <= b_sqr_in;
         b_squ_ff <= b_squ_in;
      end
   end

   // ---- stage c: edge squared lengths ----
   logic           c_valid_ff;
   sb1_type        c_ff;
   logic [ESW-1:0] c_sumr_ff, c_sumu_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_ff      <= b_ff;
         c_sumr_ff <= ESW'(b_sqr_ff[0]) + ESW'(b_sqr_ff[1]) + ESW'(b_sqr_ff[2]);
         c_sumu_ff <= ESW'(b_squ_ff[0]) + ESW'(b_squ_ff[1]) + ESW'(b_squ_ff[2]);
      end
   end

   // ---- edge lengths ----
   logic           r1_valid;
   logic [ESW-1:0] r1_x    [2];
   logic [ELW-1:0] r1_root [2];
   sb1_type        r1_sb;

   assign r1_x[0] = c_sumr_ff;
   assign r1_x[1] = c_sumu_ff;

   ofe_isqrt #(.LANES(2), .XW(ESW), .SBW($bits(sb1_type))) u_edge_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (c_valid_ff),
      .in_x     (r1_x),
      .in_sb    (c_ff),
      .out_valid(r1_valid),
      .out_root (r1_root),
      .out_sb   (r1_sb)
   );

   // ---- unit right and up vectors ----
   logic                   q1_valid;
   logic signed [DFW+F-1:0] q1_num [6];
   logic [ELW-1:0]         q1_den [6];
   logic signed [UW-1:0]   q1_quo [6];
   sb2_type                q1_sb_in, q1_sb;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         q1_num[i]   = $signed({r1_sb.er[i], {F{1'b0}}});
         q1_num[3+i] = $signed({r1_sb.eu[i], {F{1'b0}}});
         q1_den[i]   = r1_root[0];
         q1_den[3+i] = r1_root[1];
      end
      q1_sb_in.va    = r1_sb.va;
      q1_sb_in.vb    = r1_sb.vb;
      q1_sb_in.vc    = r1_sb.vc;
      q1_sb_in.degen = (r1_root[0] == '0) || (r1_root[1] == '0);
   end

   ofe_div #(.LANES(6), .NW(DFW+F), .DW(ELW), .QW(F+1), .SBW($bits(sb2_type)))
   u_edge_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (r1_valid),
      .in_num   (q1_num),
      .in_den   (q1_den),
      .in_sb    (q1_sb_in),
      .out_valid(q1_valid),
      .out_quo  (q1_quo),
      .out_sb   (q1_sb)
   );

   // ---- stage d: cross product terms ----
   logic                     d_valid_ff;
   sb2_type                  d_sb_ff;
   uvec_type                 d_ur_ff, d_uu_ff;
   logic signed [2*UW-1:0]   d_p_in [6], d_p_ff [6];

   always_comb begin
      d_p_in[0] = q1_quo[1] * q1_quo[5];
      d_p_in[1] = q1_quo[2] * q1_quo[4];
      d_p_in[2] = q1_quo[2] * q1_quo[3];
      d_p_in[3] = q1_quo[0] * q1_quo[5];
      d_p_in[4] = q1_quo[0] * q1_quo[4];
      d_p_in[5] = q1_quo[1] * q1_quo[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (en) begin
         d_valid_ff <= q1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_sb_ff <= q1_sb;
         d_p_ff  <= d_p_in;
         for (int i = 0; i < 3; i++) begin
            d_ur_ff[i] <= q1_quo[i];
            d_uu_ff[i] <= q1_quo[3+i];
         end
      end
   end

   // ---- stage e: cross product, floored ----
   logic     e_valid_ff;
   sb3_type  e_in, e_ff;
   logic signed [2*UW:0] e_t [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e_t[i]     = (2*UW+1)'(d_p_ff[2*i]) - (2*UW+1)'(d_p_ff[2*i+1]);
         e_in.cr[i] = e_t[i][2*F+2:F];
      end
      e_in.ur    = d_ur_ff;
      e_in.uu    = d_uu_ff;
      e_in.va    = d_sb_ff.va;
      e_in.vb    = d_sb_ff.vb;
      e_in.vc    = d_sb_ff.vc;
      e_in.degen = d_sb_ff.degen;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (en) begin
         e_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_ff <= e_in;
      end
   end

   // ---- stage g: cross squares ----
   logic                  g_valid_ff;
   sb3_type               g_ff;
   logic signed [2*CW-1:0] g_full [3];
   logic [2:0][CQW-1:0]   g_sq_in, g_sq_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         g_full[i]  = $signed(e_ff.cr[i]) * $signed(e_ff.cr[i]);
         g_sq_in[i] = g_full[i][CQW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
      end else if (en) begin
         g_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         g_ff    <= e_ff;
         g_sq_ff <= g_sq_in;
      end
   end

   // ---- stage h: cross squared length ----
   logic           h_valid_ff;
   sb3_type        h_ff;
   logic [CSW-1:0] h_sum_ff [1];

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
      end else if (en) begin
         h_valid_ff <= g_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h_ff        <= g_ff;
         h_sum_ff[0] <= CSW'(g_sq_ff[0]) + CSW'(g_sq_ff[1]) + CSW'(g_sq_ff[2]);
      end
   end

   // ---- normal length ----
   logic           r2_valid;
   logic [CLW-1:0] r2_root [1];
   sb3_type        r2_sb;

   ofe_isqrt #(.LANES(1), .XW(CSW), .SBW($bits(sb3_type))) u_norm_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (h_valid_ff),
      .in_x     (h_sum_ff),
      .in_sb    (h_ff),
      .out_valid(r2_valid),
      .out_root (r2_root),
      .out_sb   (r2_sb)
   );

   // ---- unit normal ----
   logic                   q2_valid;
   logic signed [CW+F-1:0] q2_num [3];
   logic [CLW-1:0]         q2_den [3];
   logic signed [UW-1:0]   q2_quo [3];
   sb4_type                q2_sb_in, q2_sb;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         q2_num[i] = $signed({r2_sb.cr[i], {F{1'b0}}});
         q2_den[i] = r2_root[0];
      end
      q2_sb_in.ur    = r2_sb.ur;
      q2_sb_in.uu    = r2_sb.uu;
      q2_sb_in.va    = r2_sb.va;
      q2_sb_in.vb    = r2_sb.vb;
      q2_sb_in.vc    = r2_sb.vc;
      // parallel edges give a zero normal
      q2_sb_in.degen = r2_sb.degen || (r2_root[0] == '0);
   end

   ofe_div #(.LANES(3), .NW(CW+F), .DW(CLW), .QW(F+1), .SBW($bits(sb4_type)))
   u_norm_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (r2_valid),
      .in_num   (q2_num),
      .in_den   (q2_den),
      .in_sb    (q2_sb_in),
      .out_valid(q2_valid),
      .out_quo  (q2_quo),
      .out_sb   (q2_sb)
   );

   // ---- stage i: dot product terms ----
   // groups: normal.va, right.va, right.vb, up.va, up.vc
   logic                 i_valid_ff;
   logic                 i_degen_ff;
   logic signed [PW-1:0] i_p_in [15], i_p_ff [15];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         i_p_in[i]    = q2_quo[i] * $signed(q2_sb.va[i]);
         i_p_in[3+i]  = $signed(q2_sb.ur[i]) * $signed(q2_sb.va[i]);
         i_p_in[6+i]  = $signed(q2_sb.ur[i]) * $signed(q2_sb.vb[i]);
         i_p_in[9+i]  = $signed(q2_sb.uu[i]) * $signed(q2_sb.va[i]);
         i_p_in[12+i] = $signed(q2_sb.uu[i]) * $signed(q2_sb.vc[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_valid_ff <= 1'b0;
      end else if (en) begin
         i_valid_ff <= q2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         i_p_ff     <= i_p_in;
         i_degen_ff <= q2_sb.degen;
      end
   end

   // ---- stage j: dot products, floored ----
   logic                  j_valid_ff;
   logic                  j_degen_ff;
   logic signed [PW+1:0]  j_s [5];
   logic signed [DTW-1:0] j_dot_in [5];
   logic signed [DTW-1:0] j_d_ff;
   logic signed [DTW-1:0] j_dot_ff [4];

   always_comb begin
      for (int g = 0; g < 5; g++) begin
         j_s[g] = (PW+2)'(i_p_ff[3*g]) + (PW+2)'(i_p_ff[3*g+1])
                + (PW+2)'(i_p_ff[3*g+2]);
         j_dot_in[g] = j_s[g][F+DTW-1:F];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         j_valid_ff <= 1'b0;
      end else if (en) begin
         j_valid_ff <= i_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         j_degen_ff <= i_degen_ff;
         j_d_ff     <= -j_dot_in[0];
         for (int g = 0; g < 4; g++) begin
            j_dot_ff[g] <= j_dot_in[g+1];
         end
      end
   end

   // ---- stage k: status and scaling by near distance ----
   logic                  k_valid_ff;
   status_type            k_status_in, k_status_ff;
   logic signed [NPW-1:0] k_prod_ff [4];
   logic [DDW-1:0]        k_den_ff [4];
   logic signed [NEAR_W:0] near_s;

   assign near_s = $signed({1'b0, near_ff});

   always_comb begin
      priority if (j_degen_ff) begin
         k_status_in = STATUS_DEGEN;
      end else if (j_d_ff <= 0) begin
         k_status_in = STATUS_BEHIND;
      end else begin
         k_status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_valid_ff <= 1'b0;
      end else if (en) begin
         k_valid_ff <= j_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         k_status_ff <= k_status_in;
         for (int g = 0; g < 4; g++) begin
            k_prod_ff[g] <= j_dot_ff[g] * near_s;
            k_den_ff[g]  <= j_d_ff[DDW-1:0];
         end
      end
   end

   // ---- extents ----
   logic                  x_valid;
   logic signed [EQW:0]   x_quo [4];
   logic [STATUS_W-1:0]   x_status;

   ofe_div #(.LANES(4), .NW(NPW), .DW(DDW), .QW(EQW), .SBW($bits(status_type)))
   u_ext_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (k_valid_ff),
      .in_num   (k_prod_ff),
      .in_den   (k_den_ff),
      .in_sb    (k_status_ff),
      .out_valid(x_valid),
      .out_quo  (x_quo),
      .out_sb   (x_status)
   );

   // ---- result register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= x_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_status_ff <= status_type'(x_status);
         for (int g = 0; g < 4; g++) begin
            rsp_ext_ff[g] <= (x_status == STATUS_OK) ? x_quo[g] : '0;
         end
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.extent_left   = rsp_ext_ff[0];
   assign rsp_bus.extent_right  = rsp_ext_ff[1];
   assign rsp_bus.extent_bottom = rsp_ext_ff[2];
   assign rsp_bus.extent_top    = rsp_ext_ff[3];
   assign rsp_bus.status        = rsp_status_ff;

   // ---- checks ----
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result valid after reset");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bus.ready |-> !req_bus.ready)
      else $error("request taken while result held");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != STATUS_OK |->
         rsp_ext_ff[0] == '0 && rsp_ext_ff[1] == '0 &&
         rsp_ext_ff[2] == '0 && rsp_ext_ff[3] == '0)
      else $error("nonzero extents on failed request");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      en && x_valid |=> rsp_valid_ff)
      else $error("divider result lost");

endmodule
